[rtl/monotone_grid_path_finder_core_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the grid path finder
// ----------------------------------------------------------------------------
`ifndef MONOTONE_GRID_PATH_FINDER_CORE_ASSERT_SVH
`define MONOTONE_GRID_PATH_FINDER_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define MGP_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mgp assertion failed");

// next-cycle implication, disabled while in reset
`define MGP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mgp assertion failed");

`endif

[rtl/mgp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgp_pkg
// shared sizes and types of the grid path finder
// ----------------------------------------------------------------------------
package mgp_pkg;

    localparam int ROWS    = 8;
    localparam int COLS    = 8;
    localparam int FIELD_W = 8;
    localparam int RW      = $clog2(ROWS);
    localparam int CW      = $clog2(COLS);

    typedef logic [COLS-1:0] t_line;
    typedef logic [RW-1:0]   t_row_idx;
    typedef logic [CW-1:0]   t_col_idx;

    // one row of the path walk
    typedef struct packed {
        t_line    mark;
        t_col_idx col_next;
    } t_path_res;

endpackage

[rtl/mgp_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgp_in_if / mgp_out_if
// valid/ready channels for grid rows in and path rows out
// ----------------------------------------------------------------------------
interface mgp_in_if;
    logic                        valid;
    logic                        ready;
    logic [mgp_pkg::FIELD_W-1:0] row_cells;

    modport source (output valid, output row_cells, input ready);
    modport sink (input valid, input row_cells, output ready);
endinterface

interface mgp_out_if;
    logic                        valid;
    logic                        ready;
    logic [mgp_pkg::FIELD_W-1:0] path_row;
    logic                        path_found;
    logic                        last_row;

    modport source (output valid, output path_row, output path_found, output last_row,
                    input ready);
    modport sink (input valid, input path_row, input path_found, input last_row,
                  output ready);
endinterface

[rtl/mgp_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgp_lane
// one column cell of the reach sweep
// ----------------------------------------------------------------------------
module mgp_lane (
    input  logic i_open,
    input  logic i_below,
    input  logic i_right,
    input  logic i_goal,
    output logic o_reach
);

    // goal cell counts as reached even when blocked
    assign o_reach = i_goal | (i_open & (i_below | i_right));

endmodule

[rtl/mgp_path.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgp_path
// merges the lane results of one row into the path marks of that row
// ----------------------------------------------------------------------------
module mgp_path (
    input  mgp_pkg::t_line    i_below,
    input  mgp_pkg::t_col_idx i_col_in,
    input  logic              i_last,
    output mgp_pkg::t_path_res o_res
);

    mgp_pkg::t_line    ge;
    mgp_pkg::t_line    cand;
    mgp_pkg::t_col_idx col_out;

    always_comb begin
        for (int c = 0; c < mgp_pkg::COLS; c++) begin
            ge[c] = (mgp_pkg::CW'(c) >= i_col_in);
        end
        cand = i_below & ge;
        // first column at or right of the entry where the path steps down
        col_out = mgp_pkg::CW'(mgp_pkg::COLS - 1);
        if (!i_last) begin
            for (int c = mgp_pkg::COLS - 1; c >= 0; c--) begin
                if (cand[c]) begin
                    col_out = mgp_pkg::CW'(c);
                end
            end
        end
        for (int c = 0; c < mgp_pkg::COLS; c++) begin
            o_res.mark[c] = ge[c] && (mgp_pkg::CW'(c) <= col_out);
        end
        o_res.col_next = col_out;
    end

endmodule

[rtl/monotone_grid_path_finder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monotone_grid_path_finder_core
// down/right path search over a grid loaded one row per request
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one grid row per request, top row first, ROWS requests per
//   grid. bit j of row_cells open means column j is usable.
//   after the last row the block sweeps the grid bottom-up, one row per
//   cycle in a row of column lanes, then walks the path and emits ROWS
//   path rows on o_out, top row first, last_row on the final one.
//   path_found is low and every row zero when no path exists.
//   rows of the next grid are taken only after the row-serial sweep and
//   walk of the current grid. i_in is ready only while rows are loading;
//   the next grid may load while the final path row still waits.
//   a stall on o_out holds the output register and pauses the walk.
//   reset (synchronous, active low) returns to loading row zero with no
//   result pending.
// ----------------------------------------------------------------------------
`include "monotone_grid_path_finder_core_assert.svh"

module monotone_grid_path_finder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mgp_in_if.sink     i_in,
    mgp_out_if.source  o_out
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SWEEP,
        S_EMIT
    } t_state;

    t_state              r_state;
    mgp_pkg::t_row_idx   r_idx;
    mgp_pkg::t_col_idx   r_col;
    mgp_pkg::t_line      r_below;
    logic                r_found;
    mgp_pkg::t_line      r_grid  [mgp_pkg::ROWS];
    mgp_pkg::t_line      r_reach [mgp_pkg::ROWS];

    logic                        r_out_valid;
    logic [mgp_pkg::FIELD_W-1:0] r_path_row;
    logic                        r_path_found;
    logic                        r_last_row;

    logic                        in_take;
    logic                        out_free;
    logic                        idx_last;
    mgp_pkg::t_line              in_line;
    mgp_pkg::t_line              sweep_line;
    mgp_pkg::t_line              grid_row;
    mgp_pkg::t_line              below_reach;
    mgp_pkg::t_path_res          path_res;
    logic [mgp_pkg::COLS+mgp_pkg::FIELD_W-1:0] in_ext;
    logic [mgp_pkg::COLS+mgp_pkg::FIELD_W-1:0] out_ext;

    assign in_take  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign idx_last = (r_idx == mgp_pkg::RW'(mgp_pkg::ROWS - 1));

    // fit the input field to the grid width
    assign in_ext  = {{mgp_pkg::COLS{1'b0}}, i_in.row_cells};
    assign in_line = in_ext[mgp_pkg::COLS-1:0];

    assign grid_row = r_grid[r_idx];

    // column lanes of the reach sweep
    for (genvar c = 0; c < mgp_pkg::COLS; c++) begin : g_lane
        logic right_reach;
        if (c == mgp_pkg::COLS - 1) begin : g_edge
            assign right_reach = 1'b0;
        end else begin : g_inner
            assign right_reach = sweep_line[c+1];
        end
        mgp_lane u_lane (
            .i_open  (grid_row[c]),
            .i_below (r_below[c]),
            .i_right (right_reach),
            .i_goal  (idx_last && (c == mgp_pkg::COLS - 1)),
            .o_reach (sweep_line[c])
        );
    end

    // the bottom row has nothing below it
    assign below_reach = idx_last ? '0 : r_reach[r_idx + mgp_pkg::RW'(1)];

    mgp_path u_path (
        .i_below  (below_reach),
        .i_col_in (r_col),
        .i_last   (idx_last),
        .o_res    (path_res)
    );

    assign out_ext = {{mgp_pkg::FIELD_W{1'b0}}, path_res.mark};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_idx       <= '0;
            r_col       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // in the emit state the valid flag is set below whenever it can drop
            if (o_out.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_take) begin
                        r_grid[r_idx] <= in_line;
                        if (idx_last) begin
                            r_state <= S_SWEEP;
                            r_below <= '0;
                        end else begin
                            r_idx <= r_idx + mgp_pkg::RW'(1);
                        end
                    end
                end
                S_SWEEP: begin
                    r_reach[r_idx] <= sweep_line;
                    r_below        <= sweep_line;
                    if (r_idx == '0) begin
                        r_found <= sweep_line[0];
                        r_col   <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= r_idx - mgp_pkg::RW'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_path_row   <= r_found ? out_ext[mgp_pkg::FIELD_W-1:0] : '0;
                        r_path_found <= r_found;
                        r_last_row   <= idx_last;
                        r_col        <= path_res.col_next;
                        if (idx_last) begin
                            r_idx   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx <= r_idx + mgp_pkg::RW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_LOAD);
    assign o_out.valid      = r_out_valid;
    assign o_out.path_row   = r_path_row;
    assign o_out.path_found = r_path_found;
    assign o_out.last_row   = r_last_row;

    `MGP_ASSERT(a_nopath_zero, i_clk, i_rst_n, r_out_valid && !r_path_found, r_path_row == '0)
    `MGP_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, r_out_valid && o_out.ready && r_last_row, !r_out_valid)
    `MGP_ASSERT(a_col_monotone, i_clk, i_rst_n, r_state == S_EMIT && $past(r_state == S_EMIT), r_col >= $past(r_col))

endmodule

[sim/tb_monotone_grid_path_finder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_monotone_grid_path_finder_core
// grids go in one row per request and path rows are checked against a
// down-first path walk kept in the bench, with random stalls on both sides but in the full-rate phase
// ----------------------------------------------------------------------------
module tb_monotone_grid_path_finder_core;

    localparam int ROWS    = mgp_pkg::ROWS;
    localparam int COLS    = mgp_pkg::COLS;
    localparam int FIELD_W = mgp_pkg::FIELD_W;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 120;
    localparam int HOLD_AT_GRID = 6;
    localparam int DRAIN_CYCLES = 4 * ROWS + 8;
    localparam int RANDOM_GRIDS = 48;

    typedef enum logic [1:0] {
        PH_SLOW_SINK,
        PH_SLOW_SOURCE,
        PH_FULL_RATE
    } t_traffic;

    typedef logic [ROWS-1:0][COLS-1:0]    t_grid;
    typedef logic [ROWS-1:0][FIELD_W-1:0] t_raw_grid;

    typedef struct {
        logic [FIELD_W-1:0] cells;
        t_traffic           phase;
        bit                 drain_first;
    } t_grid_row_req;

    typedef struct {
        logic [FIELD_W-1:0] path_row;
        logic               path_found;
        logic               last_row;
    } t_path_row_exp;

    logic clk;
    logic rst_n;

    mgp_in_if  in_if ();
    mgp_out_if out_if ();

    monotone_grid_path_finder_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_grid_row_req grid_rows_pending[$];
    t_path_row_exp path_rows_due[$];

    t_grid    grid_buf;
    int       rows_in_grid;
    int       grids_loaded;
    int       mismatch_cnt;
    int       cycle_cnt;
    int       hold_left;
    bit       hold_done;
    bit       in_taken;
    t_traffic traffic_phase;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // cells that reach the goal, swept bottom-up, then the down-first walk
    function automatic void solve_maze(input t_grid grid, output t_grid marks,
                                       output logic found);
        t_grid reach;
        int    r;
        int    c;
        int    steps;
        logic  good;
        reach = '0;
        marks = '0;
        for (r = ROWS - 1; r >= 0; r--) begin
            for (c = COLS - 1; c >= 0; c--) begin
                if (r == ROWS - 1 && c == COLS - 1) begin
                    // goal counts as reached even when blocked
                    good = 1'b1;
                end else begin
                    good = grid[r][c] &&
                           ((r + 1 < ROWS && reach[r+1][c]) ||
                            (c + 1 < COLS && reach[r][c+1]));
                end
                reach[r][c] = good;
            end
        end
        found = reach[0][0];
        if (found) begin
            r = 0;
            c = 0;
            for (steps = 0; steps < ROWS + COLS; steps++) begin
                marks[r][c] = 1'b1;
                if (r == ROWS - 1 && c == COLS - 1) break;
                if (r + 1 < ROWS && reach[r+1][c]) r++;
                else if (c + 1 < COLS) c++;
                else break;
            end
        end
    endfunction

    task automatic queue_grid(input t_raw_grid g, input t_traffic ph, input bit drain);
        t_grid_row_req req;
        for (int r = 0; r < ROWS; r++) begin
            req.cells       = g[r];
            req.phase       = ph;
            req.drain_first = drain && (r == 0);
            grid_rows_pending.push_back(req);
        end
    endtask

    // stimulus
    initial begin
        t_raw_grid g;
        t_traffic  ph;
        int        mode;
        int        pr;
        int        pc;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] d;

        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.row_cells  = '0;
        out_if.ready     = 1'b0;
        rows_in_grid     = 0;
        grids_loaded     = 0;
        mismatch_cnt     = 0;
        cycle_cnt        = 0;
        hold_left        = 0;
        hold_done        = 1'b0;
        in_taken         = 1'b0;
        traffic_phase    = PH_SLOW_SINK;

        // all open: straight down the left column, then along the bottom
        for (int r = 0; r < ROWS; r++) g[r] = '1;
        queue_grid(g, PH_SLOW_SINK, 1'b0);

        // blocked start, open top row, every other row blocked
        for (int r = 0; r < ROWS; r++) g[r] = '0;
        g[0] = '1;
        g[0][0] = 1'b0;
        queue_grid(g, PH_SLOW_SINK, 1'b0);

        // staircase with right and down moves, goal cell blocked
        for (int r = 0; r < ROWS - 1; r++) g[r] = FIELD_W'(3) << r;
        g[ROWS-1] = '0;
        queue_grid(g, PH_SLOW_SINK, 1'b0);

        for (int gi = 3; gi < 3 + RANDOM_GRIDS; gi++) begin
            if (gi < 18) ph = PH_SLOW_SINK;
            else if (gi < 35) ph = PH_SLOW_SOURCE;
            else ph = PH_FULL_RATE;
            mode = $urandom_range(0, 9);
            for (int r = 0; r < ROWS; r++) begin
                a = FIELD_W'($urandom);
                b = FIELD_W'($urandom);
                d = FIELD_W'($urandom);
                case (mode)
                    0, 1: g[r] = a & b;
                    2, 3: g[r] = a & b & d;
                    4, 5: g[r] = a;
                    6:    g[r] = a | b;
                    7:    g[r] = a;
                    8:    g[r] = a | b | d;
                    default: begin
                        g[r] = '1;
                        g[r][$urandom_range(0, FIELD_W - 1)] = 1'b0;
                    end
                endcase
            end
            if (mode <= 5) begin
                // lay a random monotone corridor through the noise
                pr = 0;
                pc = 0;
                g[0][0] = 1'b1;
                while (!(pr == ROWS - 1 && pc == COLS - 1)) begin
                    if (pr == ROWS - 1) pc++;
                    else if (pc == COLS - 1) pr++;
                    else if ($urandom_range(0, 1) == 1) pr++;
                    else pc++;
                    g[pr][pc] = 1'b1;
                end
            end
            if ($urandom_range(0, 9) == 0) g[ROWS-1][COLS-1] = 1'b0;
            if ($urandom_range(0, 19) == 0) g[0][0] = 1'b0;
            queue_grid(g, ph, (gi == 12) || (gi == 40));
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (grid_rows_pending.size() != 0) @(posedge clk);
        while (path_rows_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // request driver
    always @(negedge clk) begin
        logic               drive;
        logic [FIELD_W-1:0] cells;
        int                 idle_pct;
        drive = 1'b0;
        cells = FIELD_W'($urandom);
        if (!rst_n) begin
            drive = 1'b0;
        end else if (in_if.valid && !in_taken) begin
            drive = 1'b1;
            cells = in_if.row_cells;
        end else if (grid_rows_pending.size() != 0) begin
            traffic_phase = grid_rows_pending[0].phase;
            case (grid_rows_pending[0].phase)
                PH_SLOW_SINK:   idle_pct = 29;
                PH_SLOW_SOURCE: idle_pct = 65;
                default:        idle_pct = 0;
            endcase
            if (grid_rows_pending[0].drain_first &&
                (path_rows_due.size() != 0 || rows_in_grid != 0)) begin
                drive = 1'b0;
            end else if ($urandom_range(0, 99) >= idle_pct) begin
                drive = 1'b1;
                cells = grid_rows_pending[0].cells;
            end
        end
        in_taken = 1'b0;
        in_if.valid     <= drive;
        in_if.row_cells <= cells;
    end

    // result receiver, with one long hold-off to back up the input
    always @(negedge clk) begin
        logic rdy;
        int   idle_pct;
        case (traffic_phase)
            PH_SLOW_SINK:   idle_pct = 65;
            PH_SLOW_SOURCE: idle_pct = 29;
            default:        idle_pct = 0;
        endcase
        if (!rst_n) begin
            rdy = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if (!hold_done && grids_loaded == HOLD_AT_GRID) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rdy = 1'b0;
        end else begin
            rdy = ($urandom_range(0, 99) >= idle_pct);
        end
        out_if.ready <= rdy;
    end

    // monitor and checker
    always @(posedge clk) begin
        t_grid         marks;
        logic          found;
        t_path_row_exp want;
        if (rst_n) begin
            if (in_if.valid && in_if.ready) begin
                in_taken = 1'b1;
                void'(grid_rows_pending.pop_front());
                grid_buf[rows_in_grid] = mgp_pkg::t_line'(in_if.row_cells);
                rows_in_grid++;
                if (rows_in_grid == ROWS) begin
                    rows_in_grid = 0;
                    grids_loaded++;
                    solve_maze(grid_buf, marks, found);
                    for (int r = 0; r < ROWS; r++) begin
                        want.path_row   = FIELD_W'(marks[r]);
                        want.path_found = found;
                        want.last_row   = (r == ROWS - 1);
                        path_rows_due.push_back(want);
                    end
                end
            end
            if (out_if.valid && out_if.ready) begin
                if (path_rows_due.size() == 0) begin
                    $display("%0t: path row with nothing expected, actual %h",
                             $time, out_if.path_row);
                    mismatch_cnt++;
                end else begin
                    want = path_rows_due.pop_front();
                    if (out_if.path_row !== want.path_row) begin
                        $display("%0t: path_row mismatch, expected %h, actual %h",
                                 $time, want.path_row, out_if.path_row);
                        mismatch_cnt++;
                    end
                    if (out_if.path_found !== want.path_found) begin
                        $display("%0t: path_found mismatch, expected %b, actual %b",
                                 $time, want.path_found, out_if.path_found);
                        mismatch_cnt++;
                    end
                    if (out_if.last_row !== want.last_row) begin
                        $display("%0t: last_row mismatch, expected %b, actual %b",
                                 $time, want.last_row, out_if.last_row);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
